// ===== rtl/core/dfss_pkg.sv =====
// Shared types, codes and constants of the detector frame stream splitter.
package dfss_pkg;

    localparam int DEF_HEADER_BYTES     = 16;
    localparam int DEF_FRAME_MARK_BYTES = 7;
    localparam int POS_W                = 4;
    localparam logic [15:0] FPS_RESET   = 16'd4000;

    localparam int OUT_DEPTH = 4;
    localparam int PTR_W     = $clog2(OUT_DEPTH);
    localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

    localparam logic [7:0] BYTE_DC  = 8'hDC;
    localparam logic [7:0] BYTE_CC  = 8'hCC;
    localparam logic [7:0] BYTE_DF  = 8'hDF;
    localparam logic [1:0] CHAN_TAG = 2'b11;

    localparam logic [2:0] ROLE_HEADER = 3'd0;
    localparam logic [2:0] ROLE_MARK   = 3'd1;
    localparam logic [2:0] ROLE_STAMP  = 3'd2;
    localparam logic [2:0] ROLE_CHAN   = 3'd3;
    localparam logic [2:0] ROLE_DATA   = 3'd4;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_MAGIC     = 3'd1;
    localparam logic [2:0] ERR_SHORT_HDR = 3'd2;
    localparam logic [2:0] ERR_MARK      = 3'd3;
    localparam logic [2:0] ERR_CHAN      = 3'd4;
    localparam logic [2:0] ERR_TRUNC     = 3'd5;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_MARK   = 3'd1,
        PH_CHAN   = 3'd2,
        PH_DATA   = 3'd3,
        PH_LOOK   = 3'd4,
        PH_HELD   = 3'd5,
        PH_DONE   = 3'd6,
        PH_ERR    = 3'd7
    } t_phase;

    typedef struct packed {
        logic [7:0]  byte_out;
        logic [2:0]  role;
        logic [31:0] segment_number;
        logic        segment_start;
        logic [2:0]  error_code;
        logic        dropped;
        logic        stream_done;
        logic        last_of_run;
    } t_result;

    typedef struct packed {
        logic first;
        logic second;
    } t_push;

    typedef struct packed {
        logic [2:0]       role;
        logic             start;
        logic [2:0]       err;
        logic             to_chan;
        logic [POS_W-1:0] n_pos;
    } t_mark;

endpackage

// ===== rtl/core/detector_frame_stream_splitter_unit.sv =====
// Top level of the detector frame stream splitter.
//
// The s_axis channel carries the raw recorded stream, one byte per word, with
// s_axis_tlast set on the final byte. Every byte comes back on m_axis tagged
// with its role (tuser), the segment it belongs to, a segment-start flag, an
// error code, a dropped flag and a clean-end flag; m_axis_tlast marks the last
// result word caused by one input byte.
// A DC byte at a data word boundary is held until the next byte arrives, so an
// input word causes zero, one or two result words.
// Throughput is one input word per clock while the result queue has room. An accepted
// byte is parsed from the input word register once there is room; its results are
// registered into the queue. A byte that completes a held DC yields two result words,
// which leave a four-word result queue at one per clock while m_axis_tready is high.
// The configuration channel writes frames_per_segment (reset value 4000, zero
// means never split) and is always ready; write it only while the block is idle.
// Reset is synchronous and active low; it empties the queue and returns the
// parser to expecting a file header. When the receiver stalls, the queue fills
// and s_axis_tready drops without any combinational path from m_axis_tready.
module detector_frame_stream_splitter_unit
    import dfss_pkg::*;
#(
    parameter int HEADER_BYTES     = DEF_HEADER_BYTES,
    parameter int FRAME_MARK_BYTES = DEF_FRAME_MARK_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // stream_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [7:0] byte_out, [39:8] segment_number,
                                        // [40] segment_start, [43:41] error_code,
                                        // [44] dropped, [45] stream_done, [47:46] zero
    output logic [2:0]  m_axis_tuser,   // [2:0] role
    output logic        m_axis_tlast,   // last_of_run
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data      // frames_per_segment
);

    logic [15:0] r_fps;
    logic        room;
    t_push       push;
    t_result     res0, res1, head;

    // The frames_per_segment register.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fps <= FPS_RESET;
        end else if (i_cfg_valid) begin
            r_fps <= i_cfg_data;
        end
    end

    dfss_parser #(
        .HEADER_BYTES     (HEADER_BYTES),
        .FRAME_MARK_BYTES (FRAME_MARK_BYTES)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .i_end   (s_axis_tlast),
        .i_fps   (r_fps),
        .i_room  (room),
        .o_push  (push),
        .o_res0  (res0),
        .o_res1  (res1)
    );

    dfss_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res0  (res0),
        .i_res1  (res1),
        .o_room  (room),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_head  (head)
    );

    // Pack the head result word onto the output bus.
    assign m_axis_tdata = {2'b00, head.stream_done, head.dropped, head.error_code,
                           head.segment_start, head.segment_number, head.byte_out};
    assign m_axis_tuser = head.role;
    assign m_axis_tlast = head.last_of_run;

endmodule

// ===== rtl/core/dfss_parser.sv =====
// Input word register, parse state and the per-word classification logic.
module dfss_parser
    import dfss_pkg::*;
#(
    parameter int HEADER_BYTES     = DEF_HEADER_BYTES,
    parameter int FRAME_MARK_BYTES = DEF_FRAME_MARK_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_byte,
    input  logic        i_end,
    input  logic [15:0] i_fps,
    input  logic        i_room,
    output t_push       o_push,
    output t_result     o_res0,
    output t_result     o_res1
);

    logic             r_in_valid;
    logic [7:0]       r_byte;
    logic             r_end;
    t_phase           r_phase, n_phase;
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_magic, n_magic;
    logic [15:0]      r_fis, n_fis;
    logic [31:0]      r_seg, n_seg;
    logic [2:0]       r_err, n_err;

    logic             fire;
    logic [POS_W:0]   pos_inc;
    logic             hdr_last;
    logic [2:0]       hdr_err;
    logic [2:0]       chan_err;
    logic             is_chan;
    logic [15:0]      fd_fis;
    logic [31:0]      fd_seg;
    logic [16:0]      fis_inc;
    t_mark            mark_a, mark_h0, mark_h1;
    t_result          res0, res1;
    t_push            push;
    logic [2:0]       step_err;

    function automatic t_mark f_mark(input logic [POS_W-1:0] pos, input logic [7:0] b,
                                     input logic e, input logic [15:0] fis);
        t_mark          m;
        logic [POS_W:0] inc;
        inc       = {1'b0, pos} + (POS_W+1)'(1);
        m.role    = (pos < POS_W'(2)) ? ROLE_MARK : ROLE_STAMP;
        m.start   = (pos == '0) && (fis == '0);
        if (((pos == '0) && (b != BYTE_DC)) || ((pos == POS_W'(1)) && (b != BYTE_DF))) begin
            m.err = ERR_MARK;
        end else if (e) begin
            m.err = ERR_TRUNC;
        end else begin
            m.err = ERR_NONE;
        end
        m.to_chan = inc >= (POS_W+1)'(FRAME_MARK_BYTES);
        m.n_pos   = m.to_chan ? '0 : inc[POS_W-1:0];
        return m;
    endfunction

    assign fire    = r_in_valid && i_room;
    assign o_ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
            r_end  <= i_end;
        end
    end

    // Shared decode used by both the next-state and the result logic.
    assign pos_inc  = {1'b0, r_pos} + (POS_W+1)'(1);
    assign hdr_last = pos_inc >= (POS_W+1)'(HEADER_BYTES);
    assign is_chan  = r_byte[7:6] == CHAN_TAG;
    assign chan_err = !is_chan ? ERR_CHAN : (r_end ? ERR_TRUNC : ERR_NONE);
    assign fis_inc  = {1'b0, r_fis} + 17'd1;

    always_comb begin
        if ((r_pos == POS_W'(1)) && !(r_magic && (r_byte == BYTE_CC))) begin
            hdr_err = ERR_MAGIC;
        end else if (r_end) begin
            hdr_err = hdr_last ? ERR_TRUNC : ERR_SHORT_HDR;
        end else begin
            hdr_err = ERR_NONE;
        end
    end

    // Bookkeeping when a new frame marker closes the previous frame.
    always_comb begin
        fd_seg = r_seg;
        if (i_fps == '0) begin
            fd_fis = 16'd1;
        end else if (fis_inc >= {1'b0, i_fps}) begin
            fd_fis = '0;
            fd_seg = r_seg + 32'd1;
        end else begin
            fd_fis = fis_inc[15:0];
        end
    end

    assign mark_a  = f_mark(r_pos, r_byte, r_end, r_fis);
    assign mark_h0 = f_mark('0, BYTE_DC, 1'b0, fd_fis);
    assign mark_h1 = f_mark(POS_W'(1), r_byte, r_end, fd_fis);

    // Result words.
    always_comb begin
        res0.byte_out       = r_byte;
        res0.role           = ROLE_DATA;
        res0.segment_number = r_seg;
        res0.segment_start  = 1'b0;
        res0.error_code     = ERR_NONE;
        res0.dropped        = 1'b0;
        res0.stream_done    = 1'b0;
        res0.last_of_run    = 1'b1;
        res1                = res0;
        push.first          = 1'b1;
        push.second         = 1'b0;
        case (r_phase)
            PH_HEADER: begin
                res0.role       = ROLE_HEADER;
                res0.error_code = hdr_err;
            end
            PH_MARK: begin
                res0.role          = mark_a.role;
                res0.segment_start = mark_a.start;
                res0.error_code    = mark_a.err;
            end
            PH_CHAN: begin
                res0.role       = ROLE_CHAN;
                res0.error_code = chan_err;
            end
            PH_DATA: begin
                if (r_pos == '0) begin
                    res0.error_code = r_end ? ERR_TRUNC : ERR_NONE;
                end else begin
                    res0.stream_done = r_end;
                end
            end
            PH_LOOK: begin
                if (r_byte == BYTE_DC) begin
                    // A DC at a word boundary waits for the next byte unless the stream ends.
                    push.first      = r_end;
                    res0.error_code = ERR_TRUNC;
                end else if (is_chan) begin
                    res0.role       = ROLE_CHAN;
                    res0.error_code = chan_err;
                end else begin
                    res0.error_code = r_end ? ERR_TRUNC : ERR_NONE;
                end
            end
            PH_HELD: begin
                push.second      = 1'b1;
                res0.byte_out    = BYTE_DC;
                res0.last_of_run = 1'b0;
                if (r_byte == BYTE_DF) begin
                    res0.role           = mark_h0.role;
                    res0.segment_start  = mark_h0.start;
                    res0.segment_number = fd_seg;
                    res1.role           = mark_h1.role;
                    res1.error_code     = mark_h1.err;
                    res1.segment_number = fd_seg;
                end else begin
                    res1.stream_done = r_end;
                end
            end
            PH_DONE: begin
                res0.dropped = 1'b1;
            end
            default: begin
                res0.dropped    = 1'b1;
                res0.error_code = r_err;
            end
        endcase
        step_err = (push.first && !res0.dropped ? res0.error_code : ERR_NONE)
                 | (push.second ? res1.error_code : ERR_NONE);
    end

    // Next parse state.
    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_magic = r_magic;
        n_fis   = r_fis;
        n_seg   = r_seg;
        n_err   = r_err;
        case (r_phase)
            PH_HEADER: begin
                if (r_pos == '0) begin
                    n_magic = r_byte == BYTE_DC;
                end
                if (hdr_last) begin
                    n_phase = PH_MARK;
                    n_pos   = '0;
                end else begin
                    n_pos = pos_inc[POS_W-1:0];
                end
            end
            PH_MARK: begin
                n_phase = mark_a.to_chan ? PH_CHAN : PH_MARK;
                n_pos   = mark_a.n_pos;
            end
            PH_CHAN: begin
                n_phase = PH_DATA;
                n_pos   = '0;
            end
            PH_DATA: begin
                if (r_pos == '0) begin
                    n_phase = PH_DATA;
                    n_pos   = POS_W'(1);
                end else begin
                    n_phase = r_end ? PH_DONE : PH_LOOK;
                    n_pos   = '0;
                end
            end
            PH_LOOK: begin
                if (r_byte == BYTE_DC) begin
                    n_phase = r_end ? PH_DATA : PH_HELD;
                    n_pos   = r_end ? POS_W'(1) : r_pos;
                end else if (is_chan) begin
                    n_phase = PH_DATA;
                    n_pos   = '0;
                end else begin
                    n_phase = PH_DATA;
                    n_pos   = POS_W'(1);
                end
            end
            PH_HELD: begin
                if (r_byte == BYTE_DF) begin
                    n_fis   = fd_fis;
                    n_seg   = fd_seg;
                    n_phase = mark_h1.to_chan ? PH_CHAN : PH_MARK;
                    n_pos   = mark_h1.n_pos;
                end else begin
                    n_phase = r_end ? PH_DONE : PH_LOOK;
                    n_pos   = '0;
                end
            end
            default: begin
            end
        endcase
        if (step_err != ERR_NONE) begin
            n_phase = PH_ERR;
            n_err   = step_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_pos   <= '0;
            r_magic <= 1'b0;
            r_fis   <= '0;
            r_seg   <= '0;
            r_err   <= ERR_NONE;
        end else if (fire) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_magic <= n_magic;
            r_fis   <= n_fis;
            r_seg   <= n_seg;
            r_err   <= n_err;
        end
    end

    assign o_push.first  = fire && push.first;
    assign o_push.second = fire && push.second;
    assign o_res0        = res0;
    assign o_res1        = res1;

endmodule

// ===== rtl/core/dfss_out_fifo.sv =====
// Result queue that takes up to two result words per cycle and gives one on i_ready.
module dfss_out_fifo
    import dfss_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    input  t_result i_res0,
    input  t_result i_res1,
    output logic    o_room,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_head
);

    t_result          r_mem [OUT_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;
    logic             pop;
    logic [PTR_W-1:0] wr_second;

    assign o_valid   = r_count != '0;
    assign pop       = o_valid && i_ready;
    assign o_room    = r_count <= CNT_W'(OUT_DEPTH - 2);
    assign o_head    = r_mem[r_rd];
    assign wr_second = r_wr + PTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_push.first) begin
            r_mem[r_wr] <= i_res0;
        end
        if (i_push.second) begin
            r_mem[wr_second] <= i_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + PTR_W'(i_push.first) + PTR_W'(i_push.second);
            r_rd    <= r_rd + PTR_W'(pop);
            r_count <= r_count + CNT_W'(i_push.first) + CNT_W'(i_push.second)
                     - CNT_W'(pop);
        end
    end

endmodule

// ===== rtl/core/dfss_checker.sv =====
// Port-level checks of the detector frame stream splitter, bound to its top level.
module dfss_checker
    import dfss_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // Reset empties the result queue.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result word shown right after reset");

    // A stalled result word holds.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled result word changed");

    // Dropped words carry the data role, no segment start or clean end, and end their run.
    a_drop_role: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[44] |-> m_axis_tuser == ROLE_DATA
            && !m_axis_tdata[40] && !m_axis_tdata[45] && m_axis_tlast)
        else $error("dropped word with wrong role or flags");

    // A clean end comes on the last data word of its input byte, error free.
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[45] |-> m_axis_tlast && m_axis_tuser == ROLE_DATA
            && m_axis_tdata[43:41] == ERR_NONE)
        else $error("stream end flag on a wrong word");

    // A segment start only marks the first marker byte, which is never a dropped word.
    a_start_role: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[40] |-> m_axis_tuser == ROLE_MARK
            && !m_axis_tdata[44])
        else $error("segment start on a non-marker word");

endmodule

bind detector_frame_stream_splitter_unit dfss_checker u_dfss_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/sv/splitter_result_checker.sv =====
`timescale 1ns / 1ps
// Checker for the frame stream splitter: predicts each result word and compares it on the way out.
module splitter_result_checker
    import dfss_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_end,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [47:0] i_out_data,
    input  logic [2:0]  i_out_role,
    input  logic        i_out_last,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    // Shadow copy of the parser state and of the frames_per_segment register.
    t_phase      parse_phase;
    logic [3:0]  byte_pos;
    logic        magic_ok;
    logic [15:0] frames_in_seg;
    logic [31:0] seg_index;
    logic [2:0]  sticky_err;
    logic [15:0] frames_per_seg;

    t_result expected_words[$];

    // Queues one predicted word; a fresh error code freezes the parser.
    task automatic push_word(input logic [7:0] b, input logic [2:0] role, input logic start,
                             input logic [2:0] err, input logic drop, input logic done,
                             input logic last);
        t_result w;
        if (err != ERR_NONE && !drop) begin
            sticky_err  = err;
            parse_phase = PH_ERR;
        end
        w.byte_out       = b;
        w.role           = role;
        w.segment_number = seg_index;
        w.segment_start  = start;
        w.error_code     = err;
        w.dropped        = drop;
        w.stream_done    = done;
        w.last_of_run    = last;
        expected_words.push_back(w);
    endtask

    task automatic take_mark(input logic [7:0] b, input logic stream_end, input logic last);
        logic [3:0] pos;
        logic       start;
        logic [2:0] role;
        logic [2:0] err;
        pos   = byte_pos;
        start = (pos == 0) && (frames_in_seg == 0);
        role  = (pos < 2) ? ROLE_MARK : ROLE_STAMP;
        err   = ERR_NONE;
        if ((pos == 0 && b != BYTE_DC) || (pos == 1 && b != BYTE_DF)) begin
            err = ERR_MARK;
        end else if (stream_end) begin
            err = ERR_TRUNC;
        end
        if (int'(pos) + 1 >= DEF_FRAME_MARK_BYTES) begin
            parse_phase = PH_CHAN;
            byte_pos    = '0;
        end else begin
            byte_pos = pos + 4'd1;
        end
        push_word(b, role, start, err, 1'b0, 1'b0, last);
    endtask

    task automatic take_chan(input logic [7:0] b, input logic stream_end);
        logic [2:0] err;
        err = ERR_NONE;
        if (b[7:6] != CHAN_TAG) begin
            err = ERR_CHAN;
        end else if (stream_end) begin
            err = ERR_TRUNC;
        end
        parse_phase = PH_DATA;
        byte_pos    = '0;
        push_word(b, ROLE_CHAN, 1'b0, err, 1'b0, 1'b0, 1'b1);
    endtask

    task automatic take_data(input logic [7:0] b, input logic stream_end, input logic last);
        logic [2:0] err;
        logic       done;
        err  = ERR_NONE;
        done = 1'b0;
        if (byte_pos == 0) begin
            parse_phase = PH_DATA;
            byte_pos    = 4'd1;
            if (stream_end) begin
                err = ERR_TRUNC;
            end
        end else if (stream_end) begin
            parse_phase = PH_DONE;
            byte_pos    = '0;
            done        = 1'b1;
        end else begin
            parse_phase = PH_LOOK;
            byte_pos    = '0;
        end
        push_word(b, ROLE_DATA, 1'b0, err, 1'b0, done, last);
    endtask

    // A completed frame advances the segment once the configured count is reached.
    task automatic count_frame();
        if (frames_per_seg == 0) begin
            frames_in_seg = 16'd1;
        end else if ({1'b0, frames_in_seg} + 17'd1 >= {1'b0, frames_per_seg}) begin
            frames_in_seg = '0;
            seg_index     = seg_index + 32'd1;
        end else begin
            frames_in_seg = frames_in_seg + 16'd1;
        end
    endtask

    task automatic classify_byte(input logic [7:0] b, input logic stream_end);
        logic [3:0] pos;
        logic [2:0] err;
        case (parse_phase)
            PH_HEADER: begin
                pos = byte_pos;
                err = ERR_NONE;
                if (pos == 0) begin
                    magic_ok = (b == BYTE_DC);
                end
                if (pos == 1 && !(magic_ok && b == BYTE_CC)) begin
                    err = ERR_MAGIC;
                end else if (stream_end) begin
                    err = (int'(pos) + 1 < DEF_HEADER_BYTES) ? ERR_SHORT_HDR : ERR_TRUNC;
                end
                if (int'(pos) + 1 >= DEF_HEADER_BYTES) begin
                    parse_phase = PH_MARK;
                    byte_pos    = '0;
                end else begin
                    byte_pos = pos + 4'd1;
                end
                push_word(b, ROLE_HEADER, 1'b0, err, 1'b0, 1'b0, 1'b1);
            end
            PH_MARK: take_mark(b, stream_end, 1'b1);
            PH_CHAN: take_chan(b, stream_end);
            PH_DATA: take_data(b, stream_end, 1'b1);
            PH_LOOK: begin
                if (b == BYTE_DC) begin
                    if (stream_end) begin
                        byte_pos = '0;
                        take_data(b, 1'b1, 1'b1);
                    end else begin
                        parse_phase = PH_HELD;
                    end
                end else if (b[7:6] == CHAN_TAG) begin
                    take_chan(b, stream_end);
                end else begin
                    byte_pos = '0;
                    take_data(b, stream_end, 1'b1);
                end
            end
            PH_HELD: begin
                byte_pos = '0;
                if (b == BYTE_DF) begin
                    count_frame();
                    parse_phase = PH_MARK;
                    take_mark(BYTE_DC, 1'b0, 1'b0);
                    take_mark(b, stream_end, 1'b1);
                end else begin
                    take_data(BYTE_DC, 1'b0, 1'b0);
                    take_data(b, stream_end, 1'b1);
                end
            end
            PH_DONE: push_word(b, ROLE_DATA, 1'b0, ERR_NONE, 1'b1, 1'b0, 1'b1);
            default: push_word(b, ROLE_DATA, 1'b0, sticky_err, 1'b1, 1'b0, 1'b1);
        endcase
    endtask

    function automatic int field_differs(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result want;
        int      bad;
        if (!i_rst_n) begin
            parse_phase    = PH_HEADER;
            byte_pos       = '0;
            magic_ok       = 1'b0;
            frames_in_seg  = '0;
            seg_index      = '0;
            sticky_err     = ERR_NONE;
            frames_per_seg = FPS_RESET;
            expected_words.delete();
            o_fail_count   = 0;
            o_checked      = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                frames_per_seg = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                classify_byte(i_in_byte, i_in_end);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    $error("result word %h with no expectation waiting", i_out_data[7:0]);
                    o_fail_count++;
                end else begin
                    want = expected_words.pop_front();
                    bad  = 0;
                    bad += field_differs("byte_out", 32'(want.byte_out),
                                         32'(i_out_data[7:0]));
                    bad += field_differs("role", 32'(want.role), 32'(i_out_role));
                    bad += field_differs("segment_number", want.segment_number,
                                         i_out_data[39:8]);
                    bad += field_differs("segment_start", 32'(want.segment_start),
                                         32'(i_out_data[40]));
                    bad += field_differs("error_code", 32'(want.error_code),
                                         32'(i_out_data[43:41]));
                    bad += field_differs("dropped", 32'(want.dropped), 32'(i_out_data[44]));
                    bad += field_differs("stream_done", 32'(want.stream_done),
                                         32'(i_out_data[45]));
                    bad += field_differs("last_of_run", 32'(want.last_of_run),
                                         32'(i_out_last));
                    o_fail_count += bad;
                    o_checked++;
                end
            end
        end
        o_pending = expected_words.size();
    end

endmodule

// ===== tb/sv/tb_detector_frame_stream_splitter_unit.sv =====
`timescale 1ns / 1ps
// Testbench top: builds a recorded byte stream, drives it with varied handshake timing and reports the verdict.
module tb_detector_frame_stream_splitter_unit;
    import dfss_pkg::*;

    // Cycles without any accepted word before the run is declared hung. The longest
    // legal quiet stretch is the receiver hold-off below plus a drain pause.
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int TARGET_BYTES = 1000;

    // Idling per phase, in percent: none, sender only, receiver only, both.
    localparam int SEND_IDLE [4]  = '{0, 47, 0, 16};
    localparam int RECV_STALL [4] = '{0, 0, 47, 16};

    // Hand-picked opening frame: timestamp extremes, lowest and highest channel word,
    // a DC at a word boundary that turns out to be data, and DC DF inside a data word
    // right after a channel word, where it is plain data.
    localparam logic [7:0] FIRST_FRAME [17] = '{
        8'hDC, 8'hDF, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'h5A,
        8'hC0, 8'h00, 8'hFF,
        8'hDC, 8'h00,
        8'hFF, 8'hDC, 8'hDF,
        8'h3F, 8'h01
    };

    // How the stream ends. Since reset happens only once, each run picks one ending;
    // the early faults leave the rest of the stream dropped, so they are drawn rarely.
    typedef enum int {
        END_BAD_MAGIC,
        END_SHORT_HDR,
        END_HDR_LAST,
        END_BAD_MARK,
        END_CLEAN,
        END_CUT_MARK,
        END_CUT_CHAN,
        END_CUT_DATA,
        END_CUT_HELD,
        END_BAD_CHAN
    } t_ending;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_stream_byte;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tready = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic [15:0] i_cfg_data    = 16'h0000;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [47:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        o_cfg_ready;

    int fail_count;
    int pending;
    int checked_count;

    t_stream_byte byte_stream[$];
    t_ending      ending;
    int           sent_count  = 0;
    int           hold_at     = 0;
    int           stall_pct   = 0;
    logic         hold_off    = 1'b0;
    int           quiet_cycles = 0;

    always #2 i_clk = ~i_clk;

    detector_frame_stream_splitter_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    splitter_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_byte    (s_axis_tdata),
        .i_in_end     (s_axis_tlast),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_role   (m_axis_tuser),
        .i_out_last   (m_axis_tlast),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked_count)
    );

    // Receiver side: random stalls at the rate of the current phase, overridden by
    // the long hold-off that lets the result queue fill and back up the input.
    always @(posedge i_clk) begin
        m_axis_tready <= !hold_off && ($urandom_range(0, 99) >= stall_pct);
    end

    // The hold-off counts its own cycles while the sender keeps offering bytes.
    initial begin
        while (!i_rst_n || hold_at == 0 || sent_count < hold_at) @(posedge i_clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // Watchdog: any accepted word on any channel restarts the count.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("tb_detector_frame_stream_splitter_unit: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic put_byte(input logic [7:0] value, input logic is_end);
        t_stream_byte x;
        x.data = value;
        x.last = is_end;
        byte_stream.push_back(x);
    endtask

    // File header with the DC CC magic; end_at < 0 means the header is complete
    // and unterminated, otherwise the stream ends on that header byte.
    task automatic put_header(input int end_at);
        logic [7:0] v;
        for (int p = 0; p < DEF_HEADER_BYTES && (end_at < 0 || p <= end_at); p++) begin
            if (p == 0) begin
                v = BYTE_DC;
            end else if (p == 1) begin
                v = BYTE_CC;
            end else if (p == 2) begin
                v = 8'h00;
            end else if (p == 3) begin
                v = 8'hFF;
            end else begin
                v = 8'($urandom);
            end
            put_byte(v, p == end_at);
        end
    endtask

    task automatic put_marker();
        put_byte(BYTE_DC, 1'b0);
        put_byte(BYTE_DF, 1'b0);
        repeat (DEF_FRAME_MARK_BYTES - 2) put_byte(8'($urandom), 1'b0);
    endtask

    // One 2-byte data word. Right after a channel word any lead byte is data; at a
    // later word boundary the lead must not look like a channel word, and a DC lead
    // must not be followed by DF or it would open a frame.
    task automatic put_data_word(input logic after_chan);
        logic [7:0] lead;
        logic [7:0] tail;
        if (after_chan) begin
            lead = 8'($urandom);
        end else if ($urandom_range(0, 5) == 0) begin
            lead = BYTE_DC;
        end else begin
            lead = 8'($urandom_range(0, 8'hBF));
        end
        tail = 8'($urandom);
        if (!after_chan && lead == BYTE_DC && tail == BYTE_DF) begin
            tail = 8'h00;
        end
        put_byte(lead, 1'b0);
        put_byte(tail, 1'b0);
    endtask

    task automatic put_frame();
        int n_words;
        put_marker();
        repeat ($urandom_range(1, 3)) begin
            put_byte({CHAN_TAG, 6'($urandom)}, 1'b0);
            n_words = $urandom_range(1, 3);
            for (int w = 0; w < n_words; w++) begin
                put_data_word(w == 0);
            end
        end
    endtask

    // Offers one byte, with random idle cycles in front of it, and waits for acceptance.
    task automatic offer_byte(input t_stream_byte x, input int idle_pct);
        while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= x.data;
        s_axis_tlast  <= x.last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent_count++;
    endtask

    // Waits until every predicted word has come back, then gives a held DC (which
    // produces nothing yet) time to settle inside the block.
    task automatic wait_idle();
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_fps(input logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [15:0] fps_setting [4];
        logic [7:0]  v;
        int          cut;
        int          lo;
        int          hi;

        // Segment sizes: every frame, never split, the largest count, and a small one.
        fps_setting = '{16'd1, 16'd0, 16'hFFFF, 16'($urandom_range(2, 5))};

        if ($urandom_range(0, 15) < 4) begin
            ending = t_ending'($urandom_range(int'(END_BAD_MAGIC), int'(END_BAD_MARK)));
        end else begin
            ending = t_ending'($urandom_range(int'(END_CLEAN), int'(END_BAD_CHAN)));
        end

        // The whole stream is built before reset and then split into four phases.
        case (ending)
            END_BAD_MAGIC: begin
                // Either magic byte wrong on its own; the other one is correct.
                if ($urandom_range(0, 1) == 1) begin
                    v = 8'($urandom);
                    if (v == BYTE_CC) begin
                        v = 8'h00;
                    end
                    put_byte(BYTE_DC, 1'b0);
                    put_byte(v, 1'($urandom));
                end else begin
                    v = 8'($urandom);
                    if (v == BYTE_DC) begin
                        v = 8'hFF;
                    end
                    put_byte(v, 1'b0);
                    put_byte(BYTE_CC, 1'($urandom));
                end
            end
            END_SHORT_HDR: put_header($urandom_range(0, DEF_HEADER_BYTES - 2));
            END_HDR_LAST:  put_header(DEF_HEADER_BYTES - 1);
            END_BAD_MARK: begin
                put_header(-1);
                if ($urandom_range(0, 1) == 1) begin
                    v = 8'($urandom);
                    if (v == BYTE_DC) begin
                        v = 8'h00;
                    end
                    put_byte(v, 1'($urandom));
                end else begin
                    v = 8'($urandom);
                    if (v == BYTE_DF) begin
                        v = 8'h00;
                    end
                    put_byte(BYTE_DC, 1'b0);
                    put_byte(v, 1'($urandom));
                end
            end
            default: begin
                put_header(-1);
                foreach (FIRST_FRAME[k]) begin
                    put_byte(FIRST_FRAME[k], 1'b0);
                end
                while (byte_stream.size() < TARGET_BYTES - 20) begin
                    put_frame();
                end
                // The stream now sits at a data word boundary.
                case (ending)
                    END_CLEAN: begin
                        put_byte(8'($urandom_range(0, 8'hBF)), 1'b0);
                        put_byte(8'($urandom), 1'b1);
                    end
                    END_CUT_MARK: begin
                        cut = $urandom_range(1, DEF_FRAME_MARK_BYTES - 1);
                        put_byte(BYTE_DC, 1'b0);
                        for (int p = 1; p <= cut; p++) begin
                            put_byte((p == 1) ? BYTE_DF : 8'($urandom), p == cut);
                        end
                    end
                    END_CUT_CHAN: begin
                        put_marker();
                        put_byte({CHAN_TAG, 6'($urandom)}, 1'b1);
                    end
                    END_CUT_DATA: put_byte(8'($urandom_range(0, 8'hBF)), 1'b1);
                    END_CUT_HELD: put_byte(BYTE_DC, 1'b1);
                    default: begin
                        // A non-channel byte after the marker, with or without the end flag.
                        put_marker();
                        put_byte(8'($urandom_range(0, 8'hBF)), 1'($urandom));
                    end
                endcase
            end
        endcase

        // Whatever follows the ending must be dropped by the block. A stream that
        // ended early is filled up with such bytes to the usual length.
        repeat ($urandom_range(10, 20)) put_byte(8'($urandom), 1'($urandom));
        while (byte_stream.size() < TARGET_BYTES) begin
            put_byte(8'($urandom), 1'($urandom));
        end
        hold_at = (byte_stream.size() / 8 > 0) ? byte_stream.size() / 8 : 1;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Each phase starts from an idle block with a new segment size.
        for (int ph = 0; ph < 4; ph++) begin
            wait_idle();
            write_fps(fps_setting[ph]);
            stall_pct = RECV_STALL[ph];
            lo = byte_stream.size() * ph / 4;
            hi = byte_stream.size() * (ph + 1) / 4;
            for (int i = lo; i < hi; i++) begin
                offer_byte(byte_stream[i], SEND_IDLE[ph]);
            end
            s_axis_tvalid <= 1'b0;
        end
        wait_idle();

        $display("Sent %0d stream bytes over four idling phases, checked %0d result words.",
                 sent_count, checked_count);
        $display("Stream ending %s; segment sizes 1, 0, 65535 and %0d.", ending.name(),
                 fps_setting[3]);
        if (fail_count == 0) begin
            $display("tb_detector_frame_stream_splitter_unit: PASS");
        end else begin
            $display("tb_detector_frame_stream_splitter_unit: FAIL");
        end
        $finish;
    end

endmodule
